### sv/tpc_pkg.sv
`default_nettype none

package tpc_pkg;

    // Palette store geometry.
    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned PAL_DW        = 32;
    localparam logic [8:0]  PAL_LIMIT     = 9'(PALETTE_DEPTH);

    // Input item operations.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Image kinds.
    localparam logic [1:0] KIND_GRAY = 2'd0;
    localparam logic [1:0] KIND_TRUE = 2'd1;
    localparam logic [1:0] KIND_CMAP = 2'd2;

    // Packed word formats.
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB5A3 = 1'b1;

    // Configuration register indexes (byte address bits 3:2).
    localparam logic [1:0] REG_KIND   = 2'd0;
    localparam logic [1:0] REG_BPP    = 2'd1;
    localparam logic [1:0] REG_PBITS  = 2'd2;
    localparam logic [1:0] REG_FORMAT = 2'd3;

    // Register reset values.
    localparam logic [1:0] KIND_RESET   = KIND_TRUE;
    localparam logic [2:0] BPP_RESET    = 3'd4;
    localparam logic [5:0] PBITS_RESET  = 6'd32;
    localparam logic       FORMAT_RESET = FMT_RGB565;

    // Pixel constants.
    localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;
    localparam logic [7:0]  ALPHA_OPAQUE_MIN = 8'hE8;
    localparam logic [15:0] RGB5A3_OPAQUE    = 16'h8000;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0] image_kind;
        logic [2:0] bytes_per_pixel;
        logic [5:0] palette_entry_bits;
        logic       packed_format;
    } t_cfg;

    // One RGBA8 color.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

endpackage

`default_nettype wire

### sv/tpc_if.sv
`default_nettype none

// Input channel: palette loads and pixels to convert.
interface tpc_pix_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  table_slot;
    logic [31:0] table_word;
    logic [31:0] raw_pixel;
    logic        final_pixel;

    modport source (
        output valid, opcode, table_slot, table_word, raw_pixel, final_pixel,
        input  ready
    );
    modport sink (
        input  valid, opcode, table_slot, table_word, raw_pixel, final_pixel,
        output ready
    );
endinterface

// Output channel: converted pixels.
interface tpc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] packed_word;
    logic        bad_format;
    logic        final_out;

    modport source (
        output valid, red, green, blue, alpha, packed_word, bad_format, final_out,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, alpha, packed_word, bad_format, final_out,
        output ready
    );
endinterface

`default_nettype wire

### sv/tpc_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tpc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while reads are not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/tga_pixel_to_rgb5a3_converter_core.sv
`default_nettype none

// TGA pixel converter. Each convert item turns one raw TGA pixel (grayscale,
// true color or color mapped, as set in the configuration registers) into
// RGBA8 plus a packed RGB565 or RGB5A3 word; each load item writes one entry
// of the 256-entry palette and gives no result. The block takes one item per
// cycle while the output is not stalled; each convert item passes through the
// palette read, decode and pack registers before its result appears. The palette
// is a single-port-read memory, read once per item in the first stage. A
// palette entry must be loaded before a pixel uses it; its contents after
// reset are undefined. Configuration may only be changed while no item is in
// flight. An unsupported kind and depth combination still gives a result,
// with bad_format set and all color fields zero.
module tga_pixel_to_rgb5a3_converter_core
    import tpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tpc_pix_if.sink          i_pix,
    tpc_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Configuration registers.
    t_cfg        r_cfg;
    logic        cfg_we;
    logic [1:0]  cfg_idx;

    // Pipeline control.
    logic        en;
    logic        in_acc;

    // Stage 1: palette read issued.
    logic        r_v1;
    logic [31:0] r_raw1;
    logic        r_oob1;
    logic        r_fin1;

    // Stage 2: decoded color.
    logic        r_v2;
    t_rgba       r_c2;
    logic        r_ok2;
    logic        r_fin2;
    t_rgba       n_c2;
    logic        n_ok2;

    // Stage 3: output register.
    logic        r_v3;
    t_rgba       r_c3;
    logic [15:0] r_pk3;
    logic        r_bad3;
    logic        r_fin3;
    logic [15:0] n_pk3;

    // Palette memory ports.
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic [PAL_AW-1:0] pal_raddr;
    logic [31:0]       pal_rdata;
    logic [31:0]       entry;

    // Widen a 16-bit x1555 word into RGBA8 with opaque alpha.
    function automatic t_rgba from_x1555(input logic [15:0] w);
        t_rgba c;
        c.r = {w[14:10], 3'b000};
        c.g = {w[9:5], 3'b000};
        c.b = {w[4:0], 3'b000};
        c.a = ALPHA_OPAQUE;
        return c;
    endfunction

    // APB register write and read.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_kind         <= KIND_RESET;
            r_cfg.bytes_per_pixel    <= BPP_RESET;
            r_cfg.palette_entry_bits <= PBITS_RESET;
            r_cfg.packed_format      <= FORMAT_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_KIND:   r_cfg.image_kind         <= pwdata[1:0];
                REG_BPP:    r_cfg.bytes_per_pixel    <= pwdata[2:0];
                REG_PBITS:  r_cfg.palette_entry_bits <= pwdata[5:0];
                REG_FORMAT: r_cfg.packed_format      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KIND:   prdata = {30'd0, r_cfg.image_kind};
            REG_BPP:    prdata = {29'd0, r_cfg.bytes_per_pixel};
            REG_PBITS:  prdata = {26'd0, r_cfg.palette_entry_bits};
            REG_FORMAT: prdata = {31'd0, r_cfg.packed_format};
            default:    prdata = 32'd0;
        endcase
    end

    // The whole pipeline advances unless a result waits at the output.
    assign en          = ~r_v3 | o_res.ready;
    assign i_pix.ready = en;
    assign in_acc      = i_pix.valid & en;

    // Palette loads write at acceptance; convert items read in stage 1.
    assign pal_we    = in_acc & (i_pix.opcode == OP_LOAD) & ({1'b0, i_pix.table_slot} < PAL_LIMIT);
    assign pal_waddr = i_pix.table_slot[PAL_AW-1:0];
    assign pal_raddr = i_pix.raw_pixel[PAL_AW-1:0];

    tpc_ram #(
        .WIDTH (PAL_DW),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (i_pix.table_word),
        .i_re    (en),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pix.valid & (i_pix.opcode == OP_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_raw1 <= i_pix.raw_pixel;
            r_oob1 <= ({1'b0, i_pix.raw_pixel[7:0]} >= PAL_LIMIT);
            r_fin1 <= i_pix.final_pixel;
        end
    end

    // Stage 2: decode the raw pixel or palette entry.
    assign entry = r_oob1 ? 32'd0 : pal_rdata;

    always_comb begin
        n_c2  = '0;
        n_ok2 = 1'b0;
        case (r_cfg.image_kind)
            KIND_GRAY: begin
                if (r_cfg.bytes_per_pixel == 3'd1 || r_cfg.bytes_per_pixel == 3'd2) begin
                    n_ok2   = 1'b1;
                    n_c2.r  = r_raw1[7:0];
                    n_c2.g  = r_raw1[7:0];
                    n_c2.b  = r_raw1[7:0];
                    n_c2.a  = (r_cfg.bytes_per_pixel == 3'd2) ? r_raw1[15:8] : ALPHA_OPAQUE;
                end
            end
            KIND_TRUE: begin
                if (r_cfg.bytes_per_pixel == 3'd2) begin
                    n_ok2 = 1'b1;
                    n_c2  = from_x1555(r_raw1[15:0]);
                end else if (r_cfg.bytes_per_pixel == 3'd3 || r_cfg.bytes_per_pixel == 3'd4) begin
                    n_ok2  = 1'b1;
                    n_c2.r = r_raw1[23:16];
                    n_c2.g = r_raw1[15:8];
                    n_c2.b = r_raw1[7:0];
                    n_c2.a = (r_cfg.bytes_per_pixel == 3'd4) ? r_raw1[31:24] : ALPHA_OPAQUE;
                end
            end
            KIND_CMAP: begin
                if (r_cfg.bytes_per_pixel == 3'd1) begin
                    if (r_cfg.palette_entry_bits == 6'd24 || r_cfg.palette_entry_bits == 6'd32) begin
                        n_ok2  = 1'b1;
                        n_c2.r = entry[23:16];
                        n_c2.g = entry[15:8];
                        n_c2.b = entry[7:0];
                        n_c2.a = (r_cfg.palette_entry_bits == 6'd32) ? entry[31:24]
                                                                     : ALPHA_OPAQUE;
                    end else if (r_cfg.palette_entry_bits == 6'd15 ||
                                 r_cfg.palette_entry_bits == 6'd16) begin
                        n_ok2 = 1'b1;
                        n_c2  = from_x1555(entry[15:0]);
                        // A 16-bit entry with its top bit set is transparent.
                        if (r_cfg.palette_entry_bits == 6'd16 && entry[15]) begin
                            n_c2.a = 8'd0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2   <= n_c2;
            r_ok2  <= n_ok2;
            r_fin2 <= r_fin1;
        end
    end

    // Stage 3: build the packed word.
    always_comb begin
        if (!r_ok2) begin
            n_pk3 = 16'd0;
        end else if (r_cfg.packed_format == FMT_RGB565) begin
            n_pk3 = {r_c2.r[7:3], r_c2.g[7:2], r_c2.b[7:3]};
        end else if (r_c2.a >= ALPHA_OPAQUE_MIN) begin
            n_pk3 = RGB5A3_OPAQUE | {1'b0, r_c2.r[7:3], r_c2.g[7:3], r_c2.b[7:3]};
        end else begin
            n_pk3 = {1'b0, r_c2.a[7:5], r_c2.r[7:4], r_c2.g[7:4], r_c2.b[7:4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3   <= r_c2;
            r_pk3  <= n_pk3;
            r_bad3 <= ~r_ok2;
            r_fin3 <= r_fin2;
        end
    end

    // Result channel.
    assign o_res.valid       = r_v3;
    assign o_res.red         = r_c3.r;
    assign o_res.green       = r_c3.g;
    assign o_res.blue        = r_c3.b;
    assign o_res.alpha       = r_c3.a;
    assign o_res.packed_word = r_pk3;
    assign o_res.bad_format  = r_bad3;
    assign o_res.final_out   = r_fin3;

endmodule

`default_nettype wire

### sim/tpc_conversion_checker.sv
module tpc_conversion_checker
    import tpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tpc_pix_if               pix,
    tpc_res_if               res,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_loads
);
    timeunit 1ns;
    timeprecision 1ps;

    // Beyond this many mismatches, failures are still counted but no longer printed.
    localparam int MAX_REPORTS = 40;

    // One expected converted pixel.
    typedef struct packed {
        t_rgba       color;
        logic [15:0] word;
        logic        bad;
        logic        fin;
    } t_pixel_result;

    t_cfg              cfg_shadow;
    logic [PAL_DW-1:0] palette_shadow [PALETTE_DEPTH];
    t_pixel_result     expected_pixels [$];
    int                mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // Counts each failure and prints a line for the first MAX_REPORTS of them.
    task automatic report_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_failure($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                     o_checked, name, got, want));
        end
    endtask

    // Five-bit channels widen by a shift of three, alpha opaque.
    function automatic t_rgba widen_x1555(input logic [15:0] w);
        t_rgba c;
        c.r = {w[14:10], 3'b000};
        c.g = {w[9:5], 3'b000};
        c.b = {w[4:0], 3'b000};
        c.a = ALPHA_OPAQUE;
        return c;
    endfunction

    // Decodes a raw pixel under the current settings; returns 0 when unsupported.
    function automatic logic decode_color(input logic [31:0] raw, output t_rgba c);
        logic [31:0] entry;
        logic [5:0]  pbits;
        c     = '0;
        entry = '0;
        pbits = cfg_shadow.palette_entry_bits;
        case (cfg_shadow.image_kind)
            KIND_GRAY: begin
                if (cfg_shadow.bytes_per_pixel != 3'd1 && cfg_shadow.bytes_per_pixel != 3'd2) begin
                    return 1'b0;
                end
                c.r = raw[7:0];
                c.g = raw[7:0];
                c.b = raw[7:0];
                c.a = (cfg_shadow.bytes_per_pixel == 3'd2) ? raw[15:8] : ALPHA_OPAQUE;
                return 1'b1;
            end
            KIND_TRUE: begin
                if (cfg_shadow.bytes_per_pixel == 3'd2) begin
                    c = widen_x1555(raw[15:0]);
                end else if (cfg_shadow.bytes_per_pixel == 3'd3 ||
                             cfg_shadow.bytes_per_pixel == 3'd4) begin
                    c.r = raw[23:16];
                    c.g = raw[15:8];
                    c.b = raw[7:0];
                    c.a = (cfg_shadow.bytes_per_pixel == 3'd4) ? raw[31:24] : ALPHA_OPAQUE;
                end else begin
                    return 1'b0;
                end
                return 1'b1;
            end
            KIND_CMAP: begin
                if (cfg_shadow.bytes_per_pixel != 3'd1) begin
                    return 1'b0;
                end
                if (pbits != 6'd15 && pbits != 6'd16 && pbits != 6'd24 && pbits != 6'd32) begin
                    return 1'b0;
                end
                // An index past the store reads as an all-zero entry.
                if (raw[7:0] < PALETTE_DEPTH) begin
                    entry = palette_shadow[raw[7:0]];
                end
                if (pbits == 6'd24 || pbits == 6'd32) begin
                    c.r = entry[23:16];
                    c.g = entry[15:8];
                    c.b = entry[7:0];
                    c.a = (pbits == 6'd32) ? entry[31:24] : ALPHA_OPAQUE;
                end else begin
                    c = widen_x1555(entry[15:0]);
                    // Only a 16-bit entry carries the transparency bit.
                    if (pbits == 6'd16 && entry[15]) begin
                        c.a = 8'h00;
                    end
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Packs an RGBA8 color into RGB565 or RGB5A3.
    function automatic logic [15:0] pack_word(input t_rgba c);
        if (cfg_shadow.packed_format == FMT_RGB565) begin
            return {c.r[7:3], c.g[7:2], c.b[7:3]};
        end
        if (c.a >= ALPHA_OPAQUE_MIN) begin
            return RGB5A3_OPAQUE | {1'b0, c.r[7:3], c.g[7:3], c.b[7:3]};
        end
        return {1'b0, c.a[7:5], c.r[7:4], c.g[7:4], c.b[7:4]};
    endfunction

    function automatic t_pixel_result convert_pixel(input logic [31:0] raw, input logic fin);
        t_pixel_result res_item;
        t_rgba         c;
        logic          ok;
        ok = decode_color(raw, c);
        res_item.color = ok ? c : '0;
        res_item.word  = ok ? pack_word(c) : 16'h0000;
        res_item.bad   = !ok;
        res_item.fin   = fin;
        return res_item;
    endfunction

    // Follow register writes and items on both channels.
    always @(posedge i_clk) begin : watch
        t_pixel_result want;
        if (!i_rst_n) begin
            cfg_shadow.image_kind         <= KIND_RESET;
            cfg_shadow.bytes_per_pixel    <= BPP_RESET;
            cfg_shadow.palette_entry_bits <= PBITS_RESET;
            cfg_shadow.packed_format      <= FORMAT_RESET;
            expected_pixels.delete();
            o_pending <= 0;
            o_checked <= 0;
            o_loads   <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_KIND:   cfg_shadow.image_kind         <= i_pwdata[1:0];
                    REG_BPP:    cfg_shadow.bytes_per_pixel    <= i_pwdata[2:0];
                    REG_PBITS:  cfg_shadow.palette_entry_bits <= i_pwdata[5:0];
                    REG_FORMAT: cfg_shadow.packed_format      <= i_pwdata[0];
                    default: ;
                endcase
            end

            if (pix.valid && pix.ready) begin
                if (pix.opcode == OP_LOAD) begin
                    if (pix.table_slot < PALETTE_DEPTH) begin
                        palette_shadow[pix.table_slot] = pix.table_word;
                    end
                    o_loads <= o_loads + 1;
                end else begin
                    expected_pixels.push_back(convert_pixel(pix.raw_pixel, pix.final_pixel));
                end
            end

            if (res.valid && res.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_failure($sformatf("result after %0d with nothing expected", o_checked));
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", 32'(res.red), 32'(want.color.r));
                    check_field("green", 32'(res.green), 32'(want.color.g));
                    check_field("blue", 32'(res.blue), 32'(want.color.b));
                    check_field("alpha", 32'(res.alpha), 32'(want.color.a));
                    check_field("packed_word", 32'(res.packed_word), 32'(want.word));
                    check_field("bad_format", 32'(res.bad_format), 32'(want.bad));
                    check_field("final_out", 32'(res.final_out), 32'(want.fin));
                    o_checked <= o_checked + 1;
                end
            end

            o_pending <= expected_pixels.size();
        end
    end

endmodule

### sim/tb_tga_pixel_to_rgb5a3_converter_core.sv
module tb_tga_pixel_to_rgb5a3_converter_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;

    localparam int         WATCHDOG_LIMIT    = 2000;
    localparam int         DRAIN_PAD         = 6;
    localparam int         HOLD_CYCLES       = 60;
    localparam int         RAND_SETTINGS     = 12;
    localparam int         ITEMS_PER_SETTING = 50;
    localparam logic [1:0] KIND_UNSUPPORTED  = 2'd3;

    // Idling profiles.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked_count;
    int load_count;
    int quiet_cycles = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int settings_used = 0;
    bit hold_pending = 1'b0;

    t_cfg       cur_cfg;
    bit         slot_loaded [PALETTE_DEPTH];
    logic [7:0] loaded_slots [$];

    tpc_pix_if pix ();
    tpc_res_if res ();

    tga_pixel_to_rgb5a3_converter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tpc_conversion_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix),
        .res          (res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked_count),
        .o_loads      (load_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                res.ready <= ($urandom_range(99) < rcv_stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d idle cycles, %0d results outstanding", quiet_cycles, pending);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int profile);
        case (profile)
            IDLE_SENDER: begin
                snd_idle_pct  = 49;
                rcv_stall_pct = 0;
            end
            IDLE_RECV: begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 49;
            end
            IDLE_BOTH: begin
                snd_idle_pct  = 8;
                rcv_stall_pct = 8;
            end
            default: begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 0;
            end
        endcase
    endtask

    // Offers one item from a falling edge and returns at the falling edge after acceptance.
    task automatic send_item(input logic op, input logic [7:0] slot, input logic [31:0] word,
                             input logic [31:0] raw, input logic fin);
        while ($urandom_range(99) < snd_idle_pct) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.opcode      <= op;
        pix.table_slot  <= slot;
        pix.table_word  <= word;
        pix.raw_pixel   <= raw;
        pix.final_pixel <= fin;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        if (op == OP_LOAD && !slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected result is out and loads have settled.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [1:0] kind, input logic [2:0] bpp,
                                input logic [5:0] pbits, input logic fmt);
        wait_idle();
        apb_write(REG_KIND, {30'b0, kind});
        apb_write(REG_BPP, {29'b0, bpp});
        apb_write(REG_PBITS, {26'b0, pbits});
        apb_write(REG_FORMAT, {31'b0, fmt});
        cur_cfg.image_kind         = kind;
        cur_cfg.bytes_per_pixel    = bpp;
        cur_cfg.palette_entry_bits = pbits;
        cur_cfg.packed_format      = fmt;
        settings_used++;
    endtask

    // Mostly supported combinations, sometimes anything the registers hold.
    task automatic apply_random_config();
        logic [5:0] pbits_ok [4];
        logic       fmt;
        pbits_ok = '{6'd15, 6'd16, 6'd24, 6'd32};
        fmt = 1'($urandom_range(1));
        if ($urandom_range(99) < 15) begin
            apply_config(2'($urandom_range(3)), 3'($urandom_range(7)),
                         6'($urandom_range(63)), fmt);
        end else begin
            case ($urandom_range(6))
                0: apply_config(KIND_GRAY, 3'd1, 6'($urandom_range(63)), fmt);
                1: apply_config(KIND_GRAY, 3'd2, 6'($urandom_range(63)), fmt);
                2: apply_config(KIND_TRUE, 3'd2, 6'($urandom_range(63)), fmt);
                3: apply_config(KIND_TRUE, 3'd3, 6'($urandom_range(63)), fmt);
                4: apply_config(KIND_TRUE, 3'd4, 6'($urandom_range(63)), fmt);
                default: apply_config(KIND_CMAP, 3'd1, pbits_ok[$urandom_range(3)], fmt);
            endcase
        end
    endtask

    // Palette loads mixed with pixels; color-mapped pixels only use loaded entries.
    task automatic send_random_item();
        logic [31:0] raw;
        int          load_pct;
        load_pct = (cur_cfg.image_kind == KIND_CMAP) ? 25 : 10;
        if (loaded_slots.size() == 0 || $urandom_range(99) < load_pct) begin
            send_item(OP_LOAD, 8'($urandom_range(PALETTE_DEPTH - 1)), $urandom(), $urandom(),
                      1'($urandom_range(1)));
        end else begin
            raw = $urandom();
            if (cur_cfg.image_kind == KIND_CMAP) begin
                raw[7:0] = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
            end
            send_item(OP_CONVERT, 8'($urandom()), $urandom(), raw, $urandom_range(9) == 0);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix.valid       = 1'b0;
        pix.opcode      = OP_LOAD;
        pix.table_slot  = '0;
        pix.table_word  = '0;
        pix.raw_pixel   = '0;
        pix.final_pixel = 1'b0;
        cur_cfg.image_kind         = KIND_RESET;
        cur_cfg.bytes_per_pixel    = BPP_RESET;
        cur_cfg.palette_entry_bits = PBITS_RESET;
        cur_cfg.packed_format      = FORMAT_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(IDLE_BOTH);

        // Reset settings: 32-bit true color packed as RGB565.
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0000, 1'b1);

        // Palette extremes and both sides of the RGB5A3 opaque threshold.
        apply_config(KIND_CMAP, 3'd1, 6'd32, FMT_RGB5A3);
        send_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_item(OP_LOAD, 8'd255, 32'h0000_0000, 32'h0, 1'b0);
        send_item(OP_LOAD, 8'd1, 32'hE8F0_8818, 32'h0, 1'b0);
        send_item(OP_LOAD, 8'd2, 32'hE7F0_8818, 32'h0, 1'b0);
        send_item(OP_LOAD, 8'd3, 32'h1234_FC1F, 32'h0, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FF00, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_00FF, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0001, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0002, 1'b1);

        // A 16-bit entry with its top bit set is transparent; as 15-bit it is opaque.
        apply_config(KIND_CMAP, 3'd1, 6'd16, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0003, 1'b0);
        apply_config(KIND_CMAP, 3'd1, 6'd15, FMT_RGB565);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0003, 1'b0);
        apply_config(KIND_CMAP, 3'd1, 6'd24, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hABCD_EF02, 1'b1);

        // Grayscale with and without alpha.
        apply_config(KIND_GRAY, 3'd2, 6'd32, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_E8AB, 1'b0);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_E7AB, 1'b0);
        apply_config(KIND_GRAY, 3'd1, 6'd32, FMT_RGB565);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FF7F, 1'b1);

        // Two- and three-byte true color; the unused bytes must not matter.
        apply_config(KIND_TRUE, 3'd2, 6'd32, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_7FFF, 1'b0);
        apply_config(KIND_TRUE, 3'd3, 6'd32, FMT_RGB565);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hAB12_3456, 1'b1);

        // Unsupported combinations still give a result, flagged and zeroed.
        apply_config(KIND_UNSUPPORTED, 3'd1, 6'd32, FMT_RGB565);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0);
        apply_config(KIND_TRUE, 3'd0, 6'd32, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b0);
        apply_config(KIND_CMAP, 3'd1, 6'd0, FMT_RGB565);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'h0000_0000, 1'b0);
        apply_config(KIND_GRAY, 3'd7, 6'd63, FMT_RGB5A3);
        send_item(OP_CONVERT, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b1);

        // Random settings, each with its own idling profile.
        for (int s = 0; s < RAND_SETTINGS; s++) begin
            apply_random_config();
            set_idling(s % 4);
            // Hold off the output so the block backs up while items keep coming.
            if (s % 4 == IDLE_NONE) begin
                hold_pending = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                send_random_item();
            end
        end

        wait_idle();
        $display("checked %0d pixels and %0d palette loads over %0d register settings",
                 checked_count, load_count, settings_used);
        $display("with gaps and stalls on both channels, %0d mismatches", fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
